>>> src/lvpr_pkg.sv
package lvpr_pkg;

  // Longest string length handled; later characters only raise overflow.
  localparam int MAX_LEN   = 1024;
  localparam int NUM_CELLS = MAX_LEN + 1;
  localparam int POS_W     = $clog2(MAX_LEN + 1);
  localparam int DEPTH_W   = $clog2(NUM_CELLS + 1);
  localparam int RUN_W     = 11;
  localparam int CHAR_W    = 8;

  localparam logic [CHAR_W-1:0] OPEN_CHAR = 8'd40;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_REPLACE
  } stack_op_e;

  typedef struct packed {
    stack_op_e op;
    logic      is_top;
  } cell_ctrl_t;

  // Fit a position-wide value into the result width.
  function automatic logic [RUN_W-1:0] to_run(input logic [POS_W-1:0] pos);
    logic [31:0] wide;
    wide = 32'(pos);
    return wide[RUN_W-1:0];
  endfunction

endpackage

>>> src/lvpr_cell.sv
module lvpr_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lvpr_pkg::cell_ctrl_t       ctrl_i,
  input  logic [lvpr_pkg::POS_W-1:0] from_above_i,
  input  logic [lvpr_pkg::POS_W-1:0] from_below_i,
  output logic [lvpr_pkg::POS_W-1:0] value_o
);

  logic [lvpr_pkg::POS_W-1:0] value_q;
  logic [lvpr_pkg::POS_W-1:0] value_d;

  always_comb begin
    case (ctrl_i.op)
      lvpr_pkg::OP_PUSH:    value_d = from_above_i;
      lvpr_pkg::OP_POP:     value_d = from_below_i;
      lvpr_pkg::OP_REPLACE: value_d = ctrl_i.is_top ? from_above_i : value_q;
      default:              value_d = value_q;
    endcase
  end

  // Start from zero so the top cell holds the sentinel after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

>>> src/lvpr_stack.sv
module lvpr_stack (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lvpr_pkg::stack_op_e        op_i,
  input  logic [lvpr_pkg::POS_W-1:0] push_val_i,
  output logic [lvpr_pkg::POS_W-1:0] top_o,
  output logic [lvpr_pkg::POS_W-1:0] next_o
);

  logic [lvpr_pkg::POS_W-1:0] cell_q [lvpr_pkg::NUM_CELLS];

  for (genvar i = 0; i < lvpr_pkg::NUM_CELLS; i++) begin : g_cell
    lvpr_pkg::cell_ctrl_t       ctrl;
    logic [lvpr_pkg::POS_W-1:0] above;
    logic [lvpr_pkg::POS_W-1:0] below;

    assign ctrl.op     = op_i;
    assign ctrl.is_top = (i == 0) ? 1'b1 : 1'b0;

    if (i == 0) begin : g_top
      assign above = push_val_i;
    end else begin : g_inner
      assign above = cell_q[i-1];
    end

    // Bottom cell refills from itself; what it holds there is never read.
    if (i == lvpr_pkg::NUM_CELLS - 1) begin : g_bottom
      assign below = cell_q[i];
    end else begin : g_upper
      assign below = cell_q[i+1];
    end

    lvpr_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .from_above_i (above),
      .from_below_i (below),
      .value_o      (cell_q[i])
    );
  end

  assign top_o  = cell_q[0];
  assign next_o = cell_q[1];

endmodule

>>> src/longest_valid_paren_run.sv
// Longest well-formed parenthesis run over a character stream.
//
// Input channel: one character per item on char_code_i, with is_last_i
// set on the final character of a string. The byte '(' opens; every
// other byte closes. Output channel: one item per string, carrying
// longest_run_o and overflow_o, raised in the cycle after the last
// character is taken.
//
// Throughput is one character per cycle unless the input is stalled: the
// position stack is a row of cells that all shift together, so the top two
// entries are always in registers and each character needs one 11-bit
// subtract and compare.
//
// Characters beyond MAX_LEN are dropped and set overflow; the result
// then covers the first MAX_LEN characters.
//
// Reset leaves an empty stack with the sentinel at its bottom and no
// result pending. A stalled result is held in the output register; input
// stalls only while that register is full and stalled.
module longest_valid_paren_run (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lvpr_pkg::CHAR_W-1:0]   char_code_i,
  input  logic                          is_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lvpr_pkg::RUN_W-1:0]    longest_run_o,
  output logic                          overflow_o
);

  logic [lvpr_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [lvpr_pkg::DEPTH_W-1:0] depth_q, depth_d;
  logic [lvpr_pkg::POS_W-1:0]   best_q, best_d;
  logic                         ovf_q, ovf_d;

  logic                         out_valid_q, out_valid_d;
  logic [lvpr_pkg::RUN_W-1:0]   run_out_q, run_out_d;
  logic                         ovf_out_q, ovf_out_d;

  logic                         in_acc;
  logic                         active;
  logic                         is_open;
  logic                         room;
  logic [lvpr_pkg::POS_W-1:0]   here;
  logic [lvpr_pkg::POS_W-1:0]   run;
  logic [lvpr_pkg::POS_W-1:0]   best_now;
  logic [lvpr_pkg::POS_W-1:0]   top_val;
  logic [lvpr_pkg::POS_W-1:0]   next_val;
  logic [lvpr_pkg::POS_W-1:0]   push_val;
  lvpr_pkg::stack_op_e          op;

  // Stall only when a finished result is still waiting.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign active  = pos_q < lvpr_pkg::POS_W'(lvpr_pkg::MAX_LEN);
  assign is_open = char_code_i == lvpr_pkg::OPEN_CHAR;
  assign room    = depth_q < lvpr_pkg::DEPTH_W'(lvpr_pkg::NUM_CELLS);
  assign here    = pos_q + lvpr_pkg::POS_W'(1);

  // A closer on the lone sentinel becomes the sentinel: run length zero.
  // Otherwise measure against the entry just under the popped top.
  assign run = (depth_q == lvpr_pkg::DEPTH_W'(1)) ? '0 : (here - next_val);

  always_comb begin
    best_now = best_q;
    if (in_acc && active && !is_open && (run > best_q)) begin
      best_now = run;
    end
  end

  always_comb begin
    op       = lvpr_pkg::OP_HOLD;
    push_val = here;
    pos_d    = pos_q;
    depth_d  = depth_q;
    best_d   = best_now;
    ovf_d    = ovf_q;
    if (in_acc) begin
      if (is_last_i) begin
        // End of string: reseed the sentinel and clear the counters.
        op       = lvpr_pkg::OP_REPLACE;
        push_val = '0;
        pos_d    = '0;
        depth_d  = lvpr_pkg::DEPTH_W'(1);
        best_d   = '0;
        ovf_d    = 1'b0;
      end else if (active) begin
        pos_d = here;
        if (is_open) begin
          if (room) begin
            op      = lvpr_pkg::OP_PUSH;
            depth_d = depth_q + lvpr_pkg::DEPTH_W'(1);
          end
        end else if (depth_q == lvpr_pkg::DEPTH_W'(1)) begin
          op = lvpr_pkg::OP_REPLACE;
        end else begin
          op      = lvpr_pkg::OP_POP;
          depth_d = depth_q - lvpr_pkg::DEPTH_W'(1);
        end
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    run_out_d   = run_out_q;
    ovf_out_d   = ovf_out_q;
    if (in_acc && is_last_i) begin
      out_valid_d = 1'b1;
      run_out_d   = lvpr_pkg::to_run(best_now);
      ovf_out_d   = ovf_q || !active;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  lvpr_stack u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .push_val_i (push_val),
    .top_o      (top_val),
    .next_o     (next_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      depth_q     <= lvpr_pkg::DEPTH_W'(1);
      best_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      depth_q     <= depth_d;
      best_q      <= best_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_out_q <= run_out_d;
    ovf_out_q <= ovf_out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign longest_run_o = run_out_q;
  assign overflow_o    = ovf_out_q;

  // The sentinel never leaves the stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q != '0)
    else $error("stack depth reached zero");

  // Each stack entry above the sentinel came from a character taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(depth_q) <= 32'(pos_q) + 1)
    else $error("stack deeper than characters taken");

  // A string end leaves a fresh stack and a pending result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_last_i) |=> (pos_q == '0 && depth_q == lvpr_pkg::DEPTH_W'(1)
                               && out_valid_q))
    else $error("string end did not reset state");

  // A result taken with no new string end drops the output valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !(in_acc && is_last_i)) |=> !out_valid_q)
    else $error("result repeated after being taken");

  // The top cell carries the latest stored position after a push.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == lvpr_pkg::OP_PUSH) |=> (top_val == $past(here)))
    else $error("push did not land on top");

endmodule
